// ===== hdl/ptl_pkg.sv =====
// ptl_pkg: types, constants and helpers for the priority task list scheduler.
// No dependencies; used by every module under hdl/.
package ptl_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int ID_W      = 6;
    localparam int CNT_W     = 6;
    localparam int PRIO_W    = 8;
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 2;
    localparam int FUNC_W    = 3;
    localparam int RANGE_W   = 7;

    localparam int IN_TUSER_W  = FUNC_W + KIND_W;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] MAIN_RESET = 6'd16;
    localparam logic [CNT_W-1:0] BG_RESET   = 6'd16;

    localparam logic [CFG_IDX_W-1:0] REG_MAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG   = 1'd1;

    localparam logic [FUNC_W-1:0] FN_CREATE    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TERMINATE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_BLOCK     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UNBLOCK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISP_UPD  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DISP_BG   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DISP_VS   = 3'd6;

    localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BG   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_CR_WR, S_PUSH_CR,
        S_INS_START, S_INS_EMPTY, S_INS_RD, S_INS_CHK,
        S_LB_W1, S_LB_W2, S_LB_W3, S_TA_W1, S_TA_W2, S_INS_RET,
        S_TP_TEST, S_TP_STEP, S_TP_RD, S_TP_FIX,
        S_TU_RD, S_TU_CAP, S_TU_FIX, S_TM_CLR,
        S_DS_TEST, S_DS_CHK, S_DS_END, S_MG_TEST, S_MG_GET
    } state_t;

    typedef struct packed {
        logic              re;
        logic [IDX_W-1:0]  addr;
    } rd_req_t;

    typedef struct packed {
        logic              we_prev;
        logic              we_next;
        logic [IDX_W-1:0]  addr;
        logic [ID_W-1:0]   prev;
        logic [ID_W-1:0]   next;
    } link_wr_t;

    typedef struct packed {
        logic [ID_W-1:0]   prev;
        logic [ID_W-1:0]   next;
    } link_rd_t;

    typedef struct packed {
        logic              we_all;
        logic              we_blk;
        logic [IDX_W-1:0]  addr;
        logic [PRIO_W-1:0] prio;
        logic              blk;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] hnd;
    } data_wr_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              blk;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] hnd;
    } data_rd_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] hnd;
        logic              last;
    } push_t;

    function automatic logic [IDX_W-1:0] id2idx(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_W'(1);
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] idx2id(input logic [IDX_W-1:0] idx);
        return ID_W'(idx) + ID_W'(1);
    endfunction

    function automatic logic link_ok(input logic [ID_W-1:0] l);
        return (l != '0) && (l <= ID_W'(MAX_TASKS));
    endfunction

endpackage

// ===== hdl/ptl_link_mem.sv =====
// ptl_link_mem: per-slot prev/next link memory, one write and one read port.
// Depends on ptl_pkg.
module ptl_link_mem (
    input  logic              clk,
    input  ptl_pkg::link_wr_t wr,
    input  ptl_pkg::rd_req_t  rd,
    output ptl_pkg::link_rd_t rdata
);

    logic [ptl_pkg::ID_W-1:0] prev_mem [ptl_pkg::MAX_TASKS];
    logic [ptl_pkg::ID_W-1:0] next_mem [ptl_pkg::MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.we_prev)
        begin
            prev_mem[wr.addr] <= wr.prev;
        end
        if (wr.we_next)
        begin
            next_mem[wr.addr] <= wr.next;
        end
        if (rd.re)
        begin
            rdata.prev <= prev_mem[rd.addr];
            rdata.next <= next_mem[rd.addr];
        end
    end

endmodule

// ===== hdl/ptl_data_mem.sv =====
// ptl_data_mem: per-slot payload memory (priority, blocked, kind, words).
// Depends on ptl_pkg.
module ptl_data_mem (
    input  logic              clk,
    input  ptl_pkg::data_wr_t wr,
    input  ptl_pkg::rd_req_t  rd,
    output ptl_pkg::data_rd_t rdata
);

    logic [ptl_pkg::PRIO_W-1:0] prio_mem [ptl_pkg::MAX_TASKS];
    logic                       blk_mem  [ptl_pkg::MAX_TASKS];
    logic [ptl_pkg::KIND_W-1:0] kind_mem [ptl_pkg::MAX_TASKS];
    logic [ptl_pkg::WORD_W-1:0] arg_mem  [ptl_pkg::MAX_TASKS];
    logic [ptl_pkg::WORD_W-1:0] hnd_mem  [ptl_pkg::MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.we_all)
        begin
            prio_mem[wr.addr] <= wr.prio;
            kind_mem[wr.addr] <= wr.kind;
            arg_mem[wr.addr]  <= wr.arg;
            hnd_mem[wr.addr]  <= wr.hnd;
        end
        if (wr.we_all || wr.we_blk)
        begin
            blk_mem[wr.addr] <= wr.blk;
        end
        if (rd.re)
        begin
            rdata.prio <= prio_mem[rd.addr];
            rdata.blk  <= blk_mem[rd.addr];
            rdata.kind <= kind_mem[rd.addr];
            rdata.arg  <= arg_mem[rd.addr];
            rdata.hnd  <= hnd_mem[rd.addr];
        end
    end

endmodule

// ===== hdl/ptl_seq.sv =====
// ptl_seq: command sequencer; walks the task list and pending stack in memory.
// Depends on ptl_pkg, ptl_link_mem, ptl_data_mem.
module ptl_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ptl_pkg::FUNC_W-1:0]   in_func,
    input  logic [ptl_pkg::KIND_W-1:0]   in_kind,
    input  logic [ptl_pkg::PRIO_W-1:0]   in_prio,
    input  logic [ptl_pkg::ID_W-1:0]     in_id,
    input  logic [ptl_pkg::WORD_W-1:0]   in_arg,
    input  logic [ptl_pkg::WORD_W-1:0]   in_hnd,
    input  logic [ptl_pkg::CNT_W-1:0]    main_cnt,
    input  logic [ptl_pkg::CNT_W-1:0]    bg_cnt,
    input  logic                         out_free,
    output ptl_pkg::push_t               push
);

    localparam logic [ptl_pkg::ID_W-1:0]    MAXID = ptl_pkg::ID_W'(ptl_pkg::MAX_TASKS);
    localparam logic [ptl_pkg::RANGE_W-1:0] MAXR  = ptl_pkg::RANGE_W'(ptl_pkg::MAX_TASKS);

    ptl_pkg::state_t state_reg, state_next;

    logic [ptl_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [ptl_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [ptl_pkg::PRIO_W-1:0]  prio_reg, prio_next;
    logic [ptl_pkg::ID_W-1:0]    opid_reg, opid_next;
    logic [ptl_pkg::WORD_W-1:0]  arg_reg, arg_next;
    logic [ptl_pkg::WORD_W-1:0]  hnd_reg, hnd_next;
    logic [ptl_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [ptl_pkg::ID_W-1:0]    cur_reg, cur_next;
    logic [ptl_pkg::ID_W-1:0]    t_reg, t_next;
    logic [ptl_pkg::ID_W-1:0]    wsteps_reg, wsteps_next;
    logic [ptl_pkg::ID_W-1:0]    isteps_reg, isteps_next;
    logic [ptl_pkg::ID_W-1:0]    aprev_reg, aprev_next;
    logic [ptl_pkg::ID_W-1:0]    anext_reg, anext_next;
    logic [ptl_pkg::ID_W-1:0]    res_reg, res_next;
    logic                        ret_merge_reg, ret_merge_next;
    logic                        hvalid_reg, hvalid_next;
    logic [ptl_pkg::ID_W-1:0]    hid_reg, hid_next;
    logic [ptl_pkg::WORD_W-1:0]  harg_reg, harg_next;
    logic [ptl_pkg::WORD_W-1:0]  hhnd_reg, hhnd_next;
    logic [ptl_pkg::ID_W-1:0]    head_reg, head_next;
    logic [ptl_pkg::ID_W-1:0]    pend_reg, pend_next;
    logic [ptl_pkg::MAX_TASKS-1:0] live_reg, live_next;

    ptl_pkg::rd_req_t  rd;
    ptl_pkg::link_wr_t lwr;
    ptl_pkg::data_wr_t dwr;
    ptl_pkg::link_rd_t lrd;
    ptl_pkg::data_rd_t drd;

    ptl_link_mem u_link (.clk(clk), .wr(lwr), .rd(rd), .rdata(lrd));
    ptl_data_mem u_data (.clk(clk), .wr(dwr), .rd(rd), .rdata(drd));

    // free slot search over the range of the requested kind
    logic [ptl_pkg::RANGE_W-1:0] m_clip, b_clip, rem, base, lim;
    logic [ptl_pkg::MAX_TASKS-1:0] cand;
    logic                          found;
    logic [ptl_pkg::IDX_W-1:0]     free_idx;

    always_comb
    begin
        m_clip = (ptl_pkg::RANGE_W'(main_cnt) > MAXR) ? MAXR : ptl_pkg::RANGE_W'(main_cnt);
        rem    = MAXR - m_clip;
        b_clip = (ptl_pkg::RANGE_W'(bg_cnt) > rem) ? rem : ptl_pkg::RANGE_W'(bg_cnt);
        base   = (kind_reg == ptl_pkg::KIND_BG) ? m_clip : '0;
        lim    = (kind_reg == ptl_pkg::KIND_BG) ? (m_clip + b_clip) : m_clip;
        for (int i = 0; i < ptl_pkg::MAX_TASKS; i++)
        begin
            cand[i] = !live_reg[i] && (ptl_pkg::RANGE_W'(i) >= base)
                      && (ptl_pkg::RANGE_W'(i) < lim);
        end
        found    = |cand;
        free_idx = '0;
        for (int i = ptl_pkg::MAX_TASKS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                free_idx = ptl_pkg::IDX_W'(i);
            end
        end
    end

    logic [ptl_pkg::KIND_W-1:0] disp_kind;
    logic                       id_live, head_ok, walk_ok, ins_hit, ins_end, ds_match;
    logic [ptl_pkg::ID_W-1:0]   isteps_inc;

    always_comb
    begin
        disp_kind  = ptl_pkg::KIND_W'(func_reg - ptl_pkg::FN_BLOCK - ptl_pkg::FUNC_W'(1));
        id_live    = ptl_pkg::link_ok(opid_reg) && live_reg[ptl_pkg::id2idx(opid_reg)];
        head_ok    = ptl_pkg::link_ok(head_reg);
        walk_ok    = ptl_pkg::link_ok(t_reg) && (wsteps_reg < MAXID);
        ins_hit    = drd.prio >= prio_reg;
        isteps_inc = isteps_reg + ptl_pkg::ID_W'(1);
        ins_end    = !ptl_pkg::link_ok(lrd.next) || (isteps_inc >= MAXID);
        ds_match   = (drd.kind == disp_kind) && !drd.blk;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptl_pkg::S_DECODE;
                end
            end
            ptl_pkg::S_DECODE:
            begin
                case (func_reg)
                    ptl_pkg::FN_CREATE:
                    begin
                        if (kind_reg != ptl_pkg::KIND_FREE && found)
                        begin
                            state_next = ptl_pkg::S_CR_WR;
                        end
                        else
                        begin
                            state_next = ptl_pkg::S_PUSH_CR;
                        end
                    end
                    ptl_pkg::FN_TERMINATE:
                        state_next = id_live ? ptl_pkg::S_TP_TEST : ptl_pkg::S_IDLE;
                    ptl_pkg::FN_DISP_UPD, ptl_pkg::FN_DISP_BG, ptl_pkg::FN_DISP_VS:
                        state_next = ptl_pkg::S_DS_TEST;
                    default:
                        state_next = ptl_pkg::S_IDLE;
                endcase
            end
            ptl_pkg::S_CR_WR:
            begin
                if (head_ok && kind_reg != ptl_pkg::KIND_BG)
                begin
                    state_next = ptl_pkg::S_INS_START;
                end
                else
                begin
                    state_next = ptl_pkg::S_PUSH_CR;
                end
            end
            ptl_pkg::S_PUSH_CR:
            begin
                if (out_free)
                begin
                    state_next = ptl_pkg::S_IDLE;
                end
            end
            ptl_pkg::S_INS_START:
                state_next = head_ok ? ptl_pkg::S_INS_RD : ptl_pkg::S_INS_EMPTY;
            ptl_pkg::S_INS_EMPTY: state_next = ptl_pkg::S_INS_RET;
            ptl_pkg::S_INS_RD:    state_next = ptl_pkg::S_INS_CHK;
            ptl_pkg::S_INS_CHK:
            begin
                if (ins_hit)
                begin
                    state_next = ptl_pkg::S_LB_W1;
                end
                else if (ins_end)
                begin
                    state_next = ptl_pkg::S_TA_W1;
                end
                else
                begin
                    state_next = ptl_pkg::S_INS_RD;
                end
            end
            ptl_pkg::S_LB_W1:   state_next = ptl_pkg::S_LB_W2;
            ptl_pkg::S_LB_W2:   state_next = ptl_pkg::S_LB_W3;
            ptl_pkg::S_LB_W3:   state_next = ptl_pkg::S_INS_RET;
            ptl_pkg::S_TA_W1:   state_next = ptl_pkg::S_TA_W2;
            ptl_pkg::S_TA_W2:   state_next = ptl_pkg::S_INS_RET;
            ptl_pkg::S_INS_RET:
                state_next = ret_merge_reg ? ptl_pkg::S_MG_TEST : ptl_pkg::S_PUSH_CR;
            ptl_pkg::S_TP_TEST:
            begin
                if (!walk_ok)
                begin
                    state_next = ptl_pkg::S_TU_RD;
                end
                else if (t_reg == opid_reg)
                begin
                    state_next = ptl_pkg::S_TP_RD;
                end
                else
                begin
                    state_next = ptl_pkg::S_TP_STEP;
                end
            end
            ptl_pkg::S_TP_STEP: state_next = ptl_pkg::S_TP_TEST;
            ptl_pkg::S_TP_RD:   state_next = ptl_pkg::S_TP_FIX;
            ptl_pkg::S_TP_FIX:  state_next = ptl_pkg::S_TM_CLR;
            ptl_pkg::S_TU_RD:   state_next = ptl_pkg::S_TU_CAP;
            ptl_pkg::S_TU_CAP:  state_next = ptl_pkg::S_TU_FIX;
            ptl_pkg::S_TU_FIX:  state_next = ptl_pkg::S_TM_CLR;
            ptl_pkg::S_TM_CLR:  state_next = ptl_pkg::S_IDLE;
            ptl_pkg::S_DS_TEST:
                state_next = walk_ok ? ptl_pkg::S_DS_CHK : ptl_pkg::S_DS_END;
            ptl_pkg::S_DS_CHK:
            begin
                if (!(ds_match && hvalid_reg && !out_free))
                begin
                    state_next = ptl_pkg::S_DS_TEST;
                end
            end
            ptl_pkg::S_DS_END:
            begin
                if (out_free)
                begin
                    state_next = (disp_kind == ptl_pkg::KIND_BG) ? ptl_pkg::S_MG_TEST
                                                                 : ptl_pkg::S_IDLE;
                end
            end
            ptl_pkg::S_MG_TEST:
                state_next = walk_ok ? ptl_pkg::S_MG_GET : ptl_pkg::S_IDLE;
            ptl_pkg::S_MG_GET:  state_next = ptl_pkg::S_INS_START;
            default:            state_next = ptl_pkg::S_IDLE;
        endcase
    end

    // outputs: memory ports, result push, input ready
    always_comb
    begin
        in_ready = (state_reg == ptl_pkg::S_IDLE);
        rd       = '0;
        lwr      = '0;
        dwr      = '0;
        push     = '0;
        case (state_reg)
            ptl_pkg::S_DECODE:
            begin
                if ((func_reg == ptl_pkg::FN_BLOCK || func_reg == ptl_pkg::FN_UNBLOCK)
                    && id_live)
                begin
                    dwr.we_blk = 1'b1;
                    dwr.addr   = ptl_pkg::id2idx(opid_reg);
                    dwr.blk    = (func_reg == ptl_pkg::FN_BLOCK);
                end
            end
            ptl_pkg::S_CR_WR:
            begin
                dwr.we_all  = 1'b1;
                dwr.addr    = idx_reg;
                dwr.prio    = prio_reg;
                dwr.blk     = 1'b0;
                dwr.kind    = kind_reg;
                dwr.arg     = arg_reg;
                dwr.hnd     = hnd_reg;
                lwr.we_prev = 1'b1;
                lwr.we_next = 1'b1;
                lwr.addr    = idx_reg;
                lwr.next    = (head_ok && kind_reg == ptl_pkg::KIND_BG) ? pend_reg : '0;
            end
            ptl_pkg::S_PUSH_CR:
            begin
                push.valid = out_free;
                push.id    = res_reg;
                push.last  = 1'b1;
            end
            ptl_pkg::S_INS_EMPTY:
            begin
                lwr.we_prev = 1'b1;
                lwr.we_next = 1'b1;
                lwr.addr    = idx_reg;
            end
            ptl_pkg::S_INS_RD:
            begin
                rd.re   = 1'b1;
                rd.addr = ptl_pkg::id2idx(cur_reg);
            end
            ptl_pkg::S_LB_W1:
            begin
                lwr.we_prev = 1'b1;
                lwr.we_next = 1'b1;
                lwr.addr    = idx_reg;
                lwr.prev    = aprev_reg;
                lwr.next    = cur_reg;
            end
            ptl_pkg::S_LB_W2:
            begin
                lwr.we_next = ptl_pkg::link_ok(aprev_reg);
                lwr.addr    = ptl_pkg::id2idx(aprev_reg);
                lwr.next    = ptl_pkg::idx2id(idx_reg);
            end
            ptl_pkg::S_LB_W3:
            begin
                lwr.we_prev = 1'b1;
                lwr.addr    = ptl_pkg::id2idx(cur_reg);
                lwr.prev    = ptl_pkg::idx2id(idx_reg);
            end
            ptl_pkg::S_TA_W1:
            begin
                lwr.we_prev = 1'b1;
                lwr.we_next = 1'b1;
                lwr.addr    = idx_reg;
                lwr.prev    = cur_reg;
            end
            ptl_pkg::S_TA_W2:
            begin
                lwr.we_next = 1'b1;
                lwr.addr    = ptl_pkg::id2idx(cur_reg);
                lwr.next    = ptl_pkg::idx2id(idx_reg);
            end
            ptl_pkg::S_TP_TEST, ptl_pkg::S_DS_TEST, ptl_pkg::S_MG_TEST:
            begin
                rd.re   = walk_ok;
                rd.addr = ptl_pkg::id2idx(t_reg);
            end
            ptl_pkg::S_TP_RD, ptl_pkg::S_TU_RD:
            begin
                rd.re   = 1'b1;
                rd.addr = idx_reg;
            end
            ptl_pkg::S_TP_FIX:
            begin
                lwr.we_next = ptl_pkg::link_ok(aprev_reg);
                lwr.addr    = ptl_pkg::id2idx(aprev_reg);
                lwr.next    = lrd.next;
            end
            ptl_pkg::S_TU_CAP:
            begin
                lwr.we_next = ptl_pkg::link_ok(lrd.prev);
                lwr.addr    = ptl_pkg::id2idx(lrd.prev);
                lwr.next    = lrd.next;
            end
            ptl_pkg::S_TU_FIX:
            begin
                lwr.we_prev = ptl_pkg::link_ok(anext_reg);
                lwr.addr    = ptl_pkg::id2idx(anext_reg);
                lwr.prev    = aprev_reg;
            end
            ptl_pkg::S_TM_CLR:
            begin
                lwr.we_prev = 1'b1;
                lwr.we_next = 1'b1;
                lwr.addr    = idx_reg;
            end
            ptl_pkg::S_DS_CHK:
            begin
                push.valid = ds_match && hvalid_reg && out_free;
                push.id    = hid_reg;
                push.arg   = harg_reg;
                push.hnd   = hhnd_reg;
            end
            ptl_pkg::S_DS_END:
            begin
                push.valid = out_free;
                push.id    = hvalid_reg ? hid_reg : '0;
                push.arg   = hvalid_reg ? harg_reg : '0;
                push.hnd   = hvalid_reg ? hhnd_reg : '0;
                push.last  = 1'b1;
            end
            default:
            begin
                rd = '0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        func_next      = func_reg;
        kind_next      = kind_reg;
        prio_next      = prio_reg;
        opid_next      = opid_reg;
        arg_next       = arg_reg;
        hnd_next       = hnd_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        t_next         = t_reg;
        wsteps_next    = wsteps_reg;
        isteps_next    = isteps_reg;
        aprev_next     = aprev_reg;
        anext_next     = anext_reg;
        res_next       = res_reg;
        ret_merge_next = ret_merge_reg;
        hvalid_next    = hvalid_reg;
        hid_next       = hid_reg;
        harg_next      = harg_reg;
        hhnd_next      = hhnd_reg;
        head_next      = head_reg;
        pend_next      = pend_reg;
        live_next      = live_reg;
        case (state_reg)
            ptl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = in_func;
                    kind_next = in_kind;
                    prio_next = in_prio;
                    opid_next = in_id;
                    arg_next  = in_arg;
                    hnd_next  = in_hnd;
                end
            end
            ptl_pkg::S_DECODE:
            begin
                idx_next    = ptl_pkg::id2idx(opid_reg);
                t_next      = (func_reg == ptl_pkg::FN_TERMINATE) ? pend_reg : head_reg;
                wsteps_next = '0;
                aprev_next  = '0;
                hvalid_next = 1'b0;
                if (func_reg == ptl_pkg::FN_CREATE)
                begin
                    idx_next = free_idx;
                    res_next = (kind_reg != ptl_pkg::KIND_FREE && found)
                               ? ptl_pkg::idx2id(free_idx) : '0;
                end
            end
            ptl_pkg::S_CR_WR:
            begin
                live_next[idx_reg] = 1'b1;
                ret_merge_next     = 1'b0;
                if (!head_ok)
                begin
                    head_next = ptl_pkg::idx2id(idx_reg);
                end
                else if (kind_reg == ptl_pkg::KIND_BG)
                begin
                    pend_next = ptl_pkg::idx2id(idx_reg);
                end
            end
            ptl_pkg::S_INS_START:
            begin
                cur_next    = head_reg;
                isteps_next = '0;
            end
            ptl_pkg::S_INS_EMPTY:
                head_next = ptl_pkg::idx2id(idx_reg);
            ptl_pkg::S_INS_CHK:
            begin
                aprev_next = lrd.prev;
                if (!ins_hit)
                begin
                    isteps_next = isteps_inc;
                    if (!ins_end)
                    begin
                        cur_next = lrd.next;
                    end
                end
            end
            ptl_pkg::S_LB_W3:
            begin
                if (head_reg == cur_reg)
                begin
                    head_next = ptl_pkg::idx2id(idx_reg);
                end
            end
            ptl_pkg::S_TP_STEP:
            begin
                aprev_next  = t_reg;
                t_next      = lrd.next;
                wsteps_next = wsteps_reg + ptl_pkg::ID_W'(1);
            end
            ptl_pkg::S_TP_FIX:
            begin
                if (!ptl_pkg::link_ok(aprev_reg))
                begin
                    pend_next = lrd.next;
                end
            end
            ptl_pkg::S_TU_CAP:
            begin
                aprev_next = lrd.prev;
                anext_next = lrd.next;
            end
            ptl_pkg::S_TU_FIX:
            begin
                if (head_reg == opid_reg)
                begin
                    head_next = anext_reg;
                end
            end
            ptl_pkg::S_TM_CLR:
                live_next[idx_reg] = 1'b0;
            ptl_pkg::S_DS_CHK:
            begin
                if (!(ds_match && hvalid_reg && !out_free))
                begin
                    if (ds_match)
                    begin
                        hvalid_next = 1'b1;
                        hid_next    = t_reg;
                        harg_next   = drd.arg;
                        hhnd_next   = drd.hnd;
                    end
                    t_next      = lrd.next;
                    wsteps_next = wsteps_reg + ptl_pkg::ID_W'(1);
                end
            end
            ptl_pkg::S_DS_END:
            begin
                t_next      = pend_reg;
                wsteps_next = '0;
            end
            ptl_pkg::S_MG_TEST:
            begin
                if (!walk_ok)
                begin
                    pend_next = '0;
                end
            end
            ptl_pkg::S_MG_GET:
            begin
                idx_next       = ptl_pkg::id2idx(t_reg);
                prio_next      = drd.prio;
                t_next         = lrd.next;
                wsteps_next    = wsteps_reg + ptl_pkg::ID_W'(1);
                ret_merge_next = 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptl_pkg::S_IDLE;
            head_reg      <= '0;
            pend_reg      <= '0;
            live_reg      <= '0;
            hvalid_reg    <= 1'b0;
            ret_merge_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            pend_reg      <= pend_next;
            live_reg      <= live_next;
            hvalid_reg    <= hvalid_next;
            ret_merge_reg <= ret_merge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        kind_reg   <= kind_next;
        prio_reg   <= prio_next;
        opid_reg   <= opid_next;
        arg_reg    <= arg_next;
        hnd_reg    <= hnd_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        t_reg      <= t_next;
        wsteps_reg <= wsteps_next;
        isteps_reg <= isteps_next;
        aprev_reg  <= aprev_next;
        anext_reg  <= anext_next;
        res_reg    <= res_next;
        hid_reg    <= hid_next;
        harg_reg   <= harg_next;
        hhnd_reg   <= hhnd_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("result pushed into a full output register");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= MAXID) && (pend_reg <= MAXID))
        else $error("list or pending head out of range");

    a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptl_pkg::S_CR_WR) |=> live_reg[$past(idx_reg)])
        else $error("created slot not marked live");

endmodule

// ===== hdl/priority_task_list_scheduler.sv =====
// priority_task_list_scheduler: top level; config registers, output register,
// sequencer. Depends on ptl_pkg and ptl_seq.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: func, task_kind; tdata: prio, id, param, hnd
//  m_axis   | out       | tdata: result_id, param, handler; tlast: last_result
//  cfg      | in        | cfg_index 0 main slots, 1 background slots
//
// One command at a time. Create writes the slot, then links it into an empty
// list, onto the pending stack, or by an ordered insertion walking the list.
// Terminate walks the pending stack, then unlinks the task from the stack or
// the list. Dispatch walks the list; a background dispatch then re-inserts
// each pending task, each insertion walking the list with one link/data
// memory read per step. Output register lets the next command enter while a
// result waits; a stalled m_axis holds the walk. Reset: empty list, all free.
module priority_task_list_scheduler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] func, [4:3] task_kind
    input  logic [ptl_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // [7:0] task_priority, [13:8] task_id, [45:14] task_param,
    // [77:46] task_handler, [79:78] zero
    input  logic [ptl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] result_id, [37:6] result_param, [69:38] result_handler, [71:70] zero
    output logic [ptl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptl_pkg::CNT_W-1:0]          cfg_data
);

    logic [ptl_pkg::CNT_W-1:0] main_reg, bg_reg;
    logic                      ovalid_reg;
    logic [ptl_pkg::ID_W-1:0]  oid_reg;
    logic [ptl_pkg::WORD_W-1:0] oarg_reg, ohnd_reg;
    logic                      olast_reg;
    logic                      out_free;
    ptl_pkg::push_t            push;

    // slot range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg <= ptl_pkg::MAIN_RESET;
            bg_reg   <= ptl_pkg::BG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptl_pkg::REG_MAIN: main_reg <= cfg_data;
                ptl_pkg::REG_BG:   bg_reg   <= cfg_data;
                default:           main_reg <= main_reg;
            endcase
        end
    end

    assign out_free = !ovalid_reg || m_axis_tready;

    ptl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser[2:0]),
        .in_kind  (s_axis_tuser[4:3]),
        .in_prio  (s_axis_tdata[7:0]),
        .in_id    (s_axis_tdata[13:8]),
        .in_arg   (s_axis_tdata[45:14]),
        .in_hnd   (s_axis_tdata[77:46]),
        .main_cnt (main_reg),
        .bg_cnt   (bg_reg),
        .out_free (out_free),
        .push     (push)
    );

    // output register: one result beat held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            oid_reg   <= push.id;
            oarg_reg  <= push.arg;
            ohnd_reg  <= push.hnd;
            olast_reg <= push.last;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {2'b00, ohnd_reg, oarg_reg, oid_reg};

endmodule
